### design/i2c_text_to_seven_segment_unit_macros.svh
// Assertion helpers shared by the text-to-display block.
`ifndef I2C_TEXT_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH
`define I2C_TEXT_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH

// Condition holds on every edge out of reset.
`define I2CTSS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define I2CTSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define I2CTSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/i2ctss_pkg.sv
package i2ctss_pkg;

	// slave event codes
	localparam logic [2:0] ACT_ADDRESSED = 3'd0;
	localparam logic [2:0] ACT_DATA      = 3'd1;
	localparam logic [2:0] ACT_STOP      = 3'd2;
	localparam logic [2:0] ACT_BUS_ERROR = 3'd3;
	localparam logic [2:0] ACT_SCAN      = 3'd4;

	localparam int unsigned COUNT_W = 6;

	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] SEG_BLANK   = 8'hFF;
	localparam logic [7:0] SEG_UNKNOWN = 8'hC9;
	localparam logic [7:0] DP_ON_MASK  = 8'h7F;

	// power-up text "rdy" on the first three digits, blank beyond
	function automatic logic [7:0] boot_code(input int unsigned idx);
		logic [7:0] code;
		case (idx)
			0:       code = 8'hAF;
			1:       code = 8'hA1;
			2:       code = 8'h91;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

	// ASCII to active-low segments, bit 7 DP, bits 6..0 G..A
	function automatic logic [7:0] seg_of_char(input logic [7:0] ch);
		logic [7:0] seg;
		case (ch)
			8'h41, 8'h61: seg = 8'h88; // A a
			8'h42, 8'h62: seg = 8'h83; // B b
			8'h43:        seg = 8'hC6; // C
			8'h63:        seg = 8'hA7; // c
			8'h44, 8'h64: seg = 8'hA1; // D d
			8'h45, 8'h65: seg = 8'h86; // E e
			8'h46, 8'h66: seg = 8'h8E; // F f
			8'h47, 8'h67: seg = 8'h90; // G g
			8'h48:        seg = 8'h89; // H
			8'h68:        seg = 8'h8B; // h
			8'h49:        seg = 8'hF9; // I
			8'h69:        seg = 8'hCF; // i
			8'h4A, 8'h6A: seg = 8'hE1; // J j
			8'h4C:        seg = 8'hC7; // L
			8'h6C:        seg = 8'hCF; // l
			8'h4E, 8'h6E: seg = 8'hAB; // N n
			8'h4F:        seg = 8'hC0; // O
			8'h6F:        seg = 8'hA3; // o
			8'h50, 8'h70: seg = 8'h8C; // P p
			8'h52, 8'h72: seg = 8'hAF; // R r
			8'h53, 8'h73: seg = 8'h92; // S s
			8'h54, 8'h74: seg = 8'h87; // T t
			8'h55, 8'h56: seg = 8'hC1; // U V
			8'h75, 8'h76: seg = 8'hE3; // u v
			8'h57, 8'h77: seg = 8'h8A; // W w
			8'h59, 8'h79: seg = 8'h91; // Y y
			8'h30:        seg = 8'hC0;
			8'h31:        seg = 8'hF9;
			8'h32:        seg = 8'hA4;
			8'h33:        seg = 8'hB0;
			8'h34:        seg = 8'h99;
			8'h35:        seg = 8'h92;
			8'h36:        seg = 8'h82;
			8'h37:        seg = 8'hF8;
			8'h38:        seg = 8'h80;
			8'h39:        seg = 8'h90;
			8'h5F:        seg = 8'hF7; // underscore
			8'h20:        seg = 8'hFF; // space
			8'h2D:        seg = 8'hBF; // dash
			default:      seg = SEG_UNKNOWN;
		endcase
		return seg;
	endfunction

endpackage

### design/i2ctss_in_if.sv
interface i2ctss_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

### design/i2ctss_out_if.sv
interface i2ctss_out_if;
	logic       valid;
	logic       ready;
	logic       ack;
	logic       bus_recover;
	logic [1:0] digit_select;
	logic [7:0] segment_drive;

	modport source (output valid, output ack, output bus_recover, output digit_select,
		output segment_drive, input ready);
	modport sink (input valid, input ack, input bus_recover, input digit_select,
		input segment_drive, output ready);
endinterface

### design/i2ctss_msg_buffer.sv
`include "i2c_text_to_seven_segment_unit_macros.svh"

// Message receive side: byte count and pending digits.
module i2ctss_msg_buffer #(
	parameter int unsigned MESSAGE_LIMIT = 32,
	parameter int unsigned DIGIT_COUNT   = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [2:0]                   action,
	input  logic [7:0]                   data_byte,
	output logic                         ack,
	output logic                         commit,
	output logic [DIGIT_COUNT-1:0][7:0]  pending
);

	localparam int unsigned PW = $clog2(DIGIT_COUNT + 1);
	localparam logic [i2ctss_pkg::COUNT_W-1:0] FULL =
		i2ctss_pkg::COUNT_W'(MESSAGE_LIMIT + 1);
	localparam logic [PW-1:0] POS_END = PW'(DIGIT_COUNT);

	logic [i2ctss_pkg::COUNT_W-1:0] count_q, count_nxt;
	logic [PW-1:0]                  pos_q, pos_nxt;
	logic [DIGIT_COUNT-1:0][7:0]    pend_q, pend_nxt;
	logic [7:0]                     seg;
	logic                           take;

	assign seg = i2ctss_pkg::seg_of_char(data_byte);
	// byte lands in a digit: past the control byte, under the limit, room left
	assign take = (count_q != '0) && (count_q < FULL) && (pos_q < POS_END);

	always_comb begin
		count_nxt = count_q;
		pos_nxt   = pos_q;
		pend_nxt  = pend_q;
		ack       = 1'b1;
		commit    = 1'b0;
		case (action)
			i2ctss_pkg::ACT_ADDRESSED: begin
				count_nxt = '0;
				pos_nxt   = '0;
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					pend_nxt[i] = i2ctss_pkg::SEG_BLANK;
				end
			end
			i2ctss_pkg::ACT_DATA: begin
				if (take) begin
					if (data_byte == i2ctss_pkg::CHAR_DOT) begin
						// dot lights DP of the previous digit, dropped when none
						for (int i = 0; i < DIGIT_COUNT; i++) begin
							if (pos_q == PW'(i + 1)) begin
								pend_nxt[i] = pend_q[i] & i2ctss_pkg::DP_ON_MASK;
							end
						end
					end else begin
						for (int i = 0; i < DIGIT_COUNT; i++) begin
							if (pos_q == PW'(i)) begin
								pend_nxt[i] = seg;
							end
						end
						pos_nxt = pos_q + 1'b1;
					end
				end
				if (count_q < FULL) begin
					count_nxt = count_q + 1'b1;
				end
				ack = (count_nxt < FULL);
			end
			i2ctss_pkg::ACT_STOP: begin
				commit = (count_q != '0);
			end
			i2ctss_pkg::ACT_SCAN: begin
				ack = (count_q < FULL);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				pend_q[i] <= i2ctss_pkg::SEG_BLANK;
			end
		end else if (step) begin
			count_q <= count_nxt;
			pos_q   <= pos_nxt;
			pend_q  <= pend_nxt;
		end
	end

	assign pending = pend_q;

	`I2CTSS_ASSERT_ALWAYS(a_count_sat, clk, arst_n, count_q <= FULL, "count past limit")
	`I2CTSS_ASSERT_ALWAYS(a_pos_range, clk, arst_n, pos_q <= POS_END, "digit position overrun")
	`I2CTSS_ASSERT_NEXT(a_addr_clears, clk, arst_n,
		step && action == i2ctss_pkg::ACT_ADDRESSED,
		count_q == '0 && pos_q == '0, "addressing did not restart message")

endmodule

### design/i2ctss_display.sv
`include "i2c_text_to_seven_segment_unit_macros.svh"

// Shown digits and scan multiplexer.
module i2ctss_display #(
	parameter int unsigned DIGIT_COUNT = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [2:0]                   action,
	input  logic                         commit,
	input  logic [DIGIT_COUNT-1:0][7:0]  pending,
	output logic [1:0]                   digit_select,
	output logic [7:0]                   segment_drive
);

	localparam int unsigned SW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [SW-1:0] SCAN_LAST = SW'(DIGIT_COUNT - 1);

	logic [DIGIT_COUNT-1:0][7:0] shown_q, shown_nxt;
	logic [SW-1:0]               scan_q, scan_nxt;
	logic [SW+1:0]               scan_ext;

	always_comb begin
		shown_nxt = commit ? pending : shown_q;
		scan_nxt  = scan_q;
		if (action == i2ctss_pkg::ACT_SCAN) begin
			scan_nxt = (scan_q == SCAN_LAST) ? '0 : scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				shown_q[i] <= i2ctss_pkg::boot_code(i);
			end
		end else if (step) begin
			scan_q  <= scan_nxt;
			shown_q <= shown_nxt;
		end
	end

	// result reflects this word's update
	assign scan_ext      = {2'b00, scan_nxt};
	assign digit_select  = scan_ext[1:0];
	assign segment_drive = shown_nxt[scan_nxt];

	`I2CTSS_ASSERT_ALWAYS(a_scan_range, clk, arst_n, scan_q <= SCAN_LAST, "scan past last digit")
	`I2CTSS_ASSERT_IMP(a_commit_on_stop, clk, arst_n, commit,
		action == i2ctss_pkg::ACT_STOP, "commit outside stop")

endmodule

### design/i2c_text_to_seven_segment_unit.sv
// Path: an accepted word is held in the input register, then one pass of update logic
//   writes its result into the result register, which drives the output.
// Throughput: one word per cycle; input and result stages stall only on output backpressure.
// Reset (arst_n low, async): count 0, pending digits blank, shown text "rdy",
//   scan on the left digit, both stages empty.
`include "i2c_text_to_seven_segment_unit_macros.svh"

module i2c_text_to_seven_segment_unit #(
	parameter int unsigned MESSAGE_LIMIT = 32,
	parameter int unsigned DIGIT_COUNT   = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	i2ctss_in_if.sink    bus_in,
	i2ctss_out_if.source disp_out
);

	// ---- stage 1: registered slave event ----
	logic       vld_s1;
	logic [2:0] act_s1;
	logic [7:0] byte_s1;

	// ---- result register ----
	logic       out_vld_q;
	logic       ack_q;
	logic       recover_q;
	logic [1:0] dsel_q;
	logic [7:0] seg_q;

	// advance: stage 1 word is processed and lands in the result register
	logic adv;
	logic ack_nxt;
	logic commit;
	logic recover_nxt;
	logic [1:0] dsel_nxt;
	logic [7:0] seg_nxt;
	logic [DIGIT_COUNT-1:0][7:0] pending;

	assign adv          = vld_s1 && (!out_vld_q || disp_out.ready);
	// take a new word whenever stage 1 is empty or moving on
	assign bus_in.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bus_in.ready) begin
			vld_s1 <= bus_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bus_in.ready && bus_in.valid) begin
			act_s1  <= bus_in.action;
			byte_s1 <= bus_in.data_byte;
		end
	end

	// message buffer: count, pending digits, ack decision
	i2ctss_msg_buffer #(
		.MESSAGE_LIMIT(MESSAGE_LIMIT),
		.DIGIT_COUNT  (DIGIT_COUNT)
	) u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.action   (act_s1),
		.data_byte(byte_s1),
		.ack      (ack_nxt),
		.commit   (commit),
		.pending  (pending)
	);

	// shown digits and scan position
	i2ctss_display #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_disp (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.action       (act_s1),
		.commit       (adv && commit),
		.pending      (pending),
		.digit_select (dsel_nxt),
		.segment_drive(seg_nxt)
	);

	// bus error and undefined codes both request recovery
	always_comb begin
		recover_nxt = !(act_s1 inside {i2ctss_pkg::ACT_ADDRESSED, i2ctss_pkg::ACT_DATA,
			i2ctss_pkg::ACT_STOP, i2ctss_pkg::ACT_SCAN});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (disp_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ack_q     <= ack_nxt;
			recover_q <= recover_nxt;
			dsel_q    <= dsel_nxt;
			seg_q     <= seg_nxt;
		end
	end

	assign disp_out.valid         = out_vld_q;
	assign disp_out.ack           = ack_q;
	assign disp_out.bus_recover   = recover_q;
	assign disp_out.digit_select  = dsel_q;
	assign disp_out.segment_drive = seg_q;

	`I2CTSS_ASSERT_IMP(a_recover_acks, clk, arst_n, out_vld_q && recover_q, ack_q,
		"recovery word without ack")
	`I2CTSS_ASSERT_NEXT(a_drain, clk, arst_n, out_vld_q && disp_out.ready && !adv,
		!out_vld_q, "result word not retired")
	`I2CTSS_ASSERT_IMP(a_bus_error_code, clk, arst_n,
		adv && act_s1 == i2ctss_pkg::ACT_BUS_ERROR, recover_nxt, "bus error not flagged")

endmodule
